@@ src/top_k_nearest_keeper_macros.svh @@
// Assertion macros for the top-k nearest keeper.
// Used by the top level only; needs nothing else.
`ifndef TOP_K_NEAREST_KEEPER_MACROS_SVH
`define TOP_K_NEAREST_KEEPER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TKN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TKN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tkn_pkg.sv @@
// Shared types and constants for the top-k nearest keeper.
// No dependencies; used by tkn_rank_list and top_k_nearest_keeper.
package tkn_pkg;

  localparam int unsigned DEF_KEEP_COUNT = 3;

  localparam int unsigned ITEM_W  = 16;
  localparam int unsigned LABEL_W = 16;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned HELD_W  = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } tkn_op_e;

  // One beat on its way into the rank list.
  typedef struct packed {
    logic                valid;
    tkn_op_e             op;
    logic [ITEM_W-1:0]   item;
    logic [LABEL_W-1:0]  label;
    logic [DIST_W-1:0]   distance;
    logic [SLOT_W-1:0]   slot;
  } tkn_cmd_t;

  // One result beat.
  typedef struct packed {
    logic [ITEM_W-1:0]   slot_item;
    logic [LABEL_W-1:0]  slot_label;
    logic [DIST_W-1:0]   slot_dist;
    logic                slot_valid;
    logic [HELD_W-1:0]   held;
    logic                taken;
  } tkn_result_t;

endpackage

@@ src/top_k_nearest_keeper.sv @@
// Top level of the top-k nearest keeper: input register, rank list, result register.
// Depends on tkn_pkg, tkn_rank_list and top_k_nearest_keeper_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one op per beat: insert a
//   candidate, read the entry at read_slot_i, or clear the list. Unused op codes
//   change nothing and return a zero result with the current count.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result beat
//   per input beat, in order.
//   Pipeline: an accepted beat waits in the input register; as it moves on, the
//   rank list commits it and the result register takes its result (two register stages).
//   Throughput: one beat per cycle while out_stall_i holds no pending result. All
//   KEEP_COUNT ranks are compared against the candidate in parallel, so the rank
//   list updates as a beat moves on and the next beat sees the updated list with no bubble.
//   Reset: the count of held entries goes to zero and both stages empty; the
//   rank contents are not cleared and are never visible until written.
//   Stall: while out_stall_i holds a pending result, the input register is
//   frozen too and in_stall_o rises once it is occupied; no beat is dropped.
`include "top_k_nearest_keeper_macros.svh"

module top_k_nearest_keeper #(
  parameter int unsigned KEEP_COUNT = tkn_pkg::DEF_KEEP_COUNT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [tkn_pkg::ITEM_W-1:0]   item_index_i,
  input  logic [tkn_pkg::LABEL_W-1:0]  class_label_i,
  input  logic [tkn_pkg::DIST_W-1:0]   distance_i,
  input  logic [tkn_pkg::SLOT_W-1:0]   read_slot_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tkn_pkg::ITEM_W-1:0]   slot_item_o,
  output logic [tkn_pkg::LABEL_W-1:0]  slot_label_o,
  output logic [tkn_pkg::DIST_W-1:0]   slot_distance_o,
  output logic                         slot_valid_o,
  output logic [tkn_pkg::HELD_W-1:0]   held_count_o,
  output logic                         was_taken_o
);
  import tkn_pkg::*;

  // input register
  logic     s1_valid_q, s1_valid_d;
  tkn_cmd_t s1_q;
  tkn_cmd_t cmd;

  // result register
  logic        out_valid_q, out_valid_d;
  tkn_result_t out_q;
  tkn_result_t res;

  logic out_ready, s1_fire, in_accept;

  // Result register can take a beat when empty or draining this cycle.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_fire);
  assign out_valid_d = s1_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.valid    <= 1'b1;
      s1_q.op       <= tkn_op_e'(op_i);
      s1_q.item     <= item_index_i;
      s1_q.label    <= class_label_i;
      s1_q.distance <= distance_i;
      s1_q.slot     <= read_slot_i;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  // The rank list only commits when the beat moves on.
  always_comb begin
    cmd       = s1_q;
    cmd.valid = s1_fire;
  end

  tkn_rank_list #(
    .KEEP_COUNT(KEEP_COUNT)
  ) u_rank_list (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .res_o (res)
  );

  assign out_valid_o     = out_valid_q;
  assign slot_item_o     = out_q.slot_item;
  assign slot_label_o    = out_q.slot_label;
  assign slot_distance_o = out_q.slot_dist;
  assign slot_valid_o    = out_q.slot_valid;
  assign held_count_o    = out_q.held;
  assign was_taken_o     = out_q.taken;

  // A result never reports both a read hit and a taken insert.
  `TKN_ASSERT_IMPL(a_read_or_take, clk_i, rst_ni, out_valid_o, !(slot_valid_o && was_taken_o), "read hit and insert in one beat")
  // A clear leaves an empty list and takes nothing.
  `TKN_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, s1_fire && (s1_q.op == OP_CLEAR), (held_count_o == '0) && !was_taken_o, "clear did not empty list")
  // Non-read beats return zero slot fields.
  `TKN_ASSERT_NEXT(a_slot_zero, clk_i, rst_ni, s1_fire && (s1_q.op != OP_READ), !slot_valid_o && (slot_distance_o == '0) && (slot_item_o == '0), "slot fields set on non-read")

endmodule

@@ src/tkn_rank_list.sv @@
// Sorted rank registers with parallel compare, insert, read and clear.
// Depends on tkn_pkg.
module tkn_rank_list #(
  parameter int unsigned KEEP_COUNT = tkn_pkg::DEF_KEEP_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tkn_pkg::tkn_cmd_t    cmd_i,
  output tkn_pkg::tkn_result_t res_o
);
  import tkn_pkg::*;

  localparam int unsigned CNT_W = $clog2(KEEP_COUNT + 1);

  logic [DIST_W-1:0]  dist_q  [KEEP_COUNT];
  logic [ITEM_W-1:0]  item_q  [KEEP_COUNT];
  logic [LABEL_W-1:0] label_q [KEEP_COUNT];
  logic [DIST_W-1:0]  dist_d  [KEEP_COUNT];
  logic [ITEM_W-1:0]  item_d  [KEEP_COUNT];
  logic [LABEL_W-1:0] label_d [KEEP_COUNT];

  logic [DIST_W-1:0]  prev_dist  [KEEP_COUNT];
  logic [ITEM_W-1:0]  prev_item  [KEEP_COUNT];
  logic [LABEL_W-1:0] prev_label [KEEP_COUNT];

  logic [CNT_W-1:0]      count_q, count_d;
  logic [KEEP_COUNT-1:0] held, gt, move, shift_in;
  logic                  full, do_insert, take;

  // Rank i either shifts down from i-1 or takes the candidate.
  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_prev
    if (i == 0) begin : g_head
      assign prev_dist[i]  = cmd_i.distance;
      assign prev_item[i]  = cmd_i.item;
      assign prev_label[i] = cmd_i.label;
      assign shift_in[i]   = 1'b0;
    end else begin : g_tail
      assign prev_dist[i]  = dist_q[i-1];
      assign prev_item[i]  = item_q[i-1];
      assign prev_label[i] = label_q[i-1];
      assign shift_in[i]   = move[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < KEEP_COUNT; i++) begin
      held[i] = CNT_W'(i) < count_q;
      gt[i]   = held[i] && (dist_q[i] > cmd_i.distance);
      // ties stay ahead: only strictly larger entries move down
      move[i] = gt[i] || (CNT_W'(i) == count_q);
    end
  end

  assign full      = (count_q == CNT_W'(KEEP_COUNT));
  assign do_insert = cmd_i.valid && (cmd_i.op == OP_INSERT);
  assign take      = do_insert && (!full || gt[KEEP_COUNT-1]);

  always_comb begin
    for (int i = 0; i < KEEP_COUNT; i++) begin
      dist_d[i]  = dist_q[i];
      item_d[i]  = item_q[i];
      label_d[i] = label_q[i];
      if (take && move[i]) begin
        if (shift_in[i]) begin
          dist_d[i]  = prev_dist[i];
          item_d[i]  = prev_item[i];
          label_d[i] = prev_label[i];
        end else begin
          dist_d[i]  = cmd_i.distance;
          item_d[i]  = cmd_i.item;
          label_d[i] = cmd_i.label;
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.valid) begin
      unique case (cmd_i.op)
        OP_INSERT: if (!full) count_d = count_q + CNT_W'(1);
        OP_CLEAR:  count_d = '0;
        default:   count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    item_q  <= item_d;
    label_q <= label_d;
  end

  // Read mux; zero slot fields on anything but a read of a held rank.
  always_comb begin
    res_o = '0;
    for (int i = 0; i < KEEP_COUNT; i++) begin
      if (cmd_i.valid && (cmd_i.op == OP_READ) && held[i] &&
          ({{(32 - SLOT_W){1'b0}}, cmd_i.slot} == 32'(i))) begin
        res_o.slot_item  = item_q[i];
        res_o.slot_label = label_q[i];
        res_o.slot_dist  = dist_q[i];
        res_o.slot_valid = 1'b1;
      end
    end
    res_o.held  = HELD_W'(count_d);
    res_o.taken = take;
  end

endmodule
